FILE: src/pst_pkg.sv
package pst_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int MAX_CAPACITY = 64;
    localparam int CNT_W        = $clog2(MAX_CAPACITY + 1);
    localparam int SEQ_W        = $clog2(MAX_CAPACITY);
    localparam int FLD_W        = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SORT,
        ST_DRAIN
    } state_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD,
        OP_SORT,
        OP_DRAIN
    } cell_op_t;

    typedef enum logic {
        MODE_ISLAND_DIST = 1'b0,
        MODE_FIRST_SECOND = 1'b1
    } sort_mode_t;

    typedef struct packed {
        logic                    valid;
        logic [SEQ_W-1:0]        seq;
        logic [FLD_W-1:0]        first;
        logic [FLD_W-1:0]        second;
        logic [FLD_W-1:0]        island;
        logic signed [FLD_W-1:0] distance;
    } rec_t;

    typedef struct packed {
        cell_op_t   op;
        logic       parity;
        sort_mode_t mode;
        logic       last;
        logic       dropped;
    } ctrl_t;

    // true when a must be placed after b; sequence number breaks key ties
    function automatic logic rec_greater(rec_t a, rec_t b, sort_mode_t mode);
        logic result;
        result = 1'b0;
        if (mode == MODE_ISLAND_DIST) begin
            if (a.island != b.island)
                result = (a.island > b.island);
            else if (a.distance != b.distance)
                result = ($signed(a.distance) > $signed(b.distance));
            else
                result = (a.seq > b.seq);
        end else begin
            if (a.first != b.first)
                result = (a.first > b.first);
            else if (a.second != b.second)
                result = (a.second > b.second);
            else
                result = (a.seq > b.seq);
        end
        return result;
    endfunction

endpackage

FILE: src/pair_record_sorter.sv
// channel   | handshake                          | payload
// ----------+------------------------------------+-----------------------------------------
// input     | start, busy (taken: start & !busy) | first_index, second_index, island_index,
//           |                                    | distance, end_of_set
// result    | result_valid (one-cycle strobe)    | out_first, out_second, out_island,
//           |                                    | out_distance, final_record, dropped
// config    | sort_mode_we                       | sort_mode
//
// A record without end_of_set is taken while busy stays low.
// An end_of_set record with n held records keeps busy high through n odd-even
// compare-exchange phases across the cell row, then a drain that shifts the
// row toward cell 0, one result per cycle.
// Async active-low reset empties the store and clears sort_mode; no clearing pass.
// The receiver cannot stall; results appear on consecutive cycles.
module pair_record_sorter #(
    parameter int CAPACITY = pst_pkg::DEF_CAPACITY
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [pst_pkg::FLD_W-1:0]   first_index,
    input  logic [pst_pkg::FLD_W-1:0]   second_index,
    input  logic [pst_pkg::FLD_W-1:0]   island_index,
    input  logic signed [pst_pkg::FLD_W-1:0] distance,
    input  logic                        end_of_set,
    input  logic                        sort_mode_we,
    input  logic                        sort_mode,
    output logic                        result_valid,
    output logic [pst_pkg::FLD_W-1:0]   out_first,
    output logic [pst_pkg::FLD_W-1:0]   out_second,
    output logic [pst_pkg::FLD_W-1:0]   out_island,
    output logic signed [pst_pkg::FLD_W-1:0] out_distance,
    output logic                        final_record,
    output logic                        dropped
);
    import pst_pkg::*;

    ctrl_t            ctl;
    logic [SEQ_W-1:0] seq;
    rec_t             in_rec;
    rec_t             cell_q [CAPACITY];
    logic             gt [CAPACITY-1];
    logic             result_valid_reg;
    logic             result_valid_next;
    rec_t             out_reg;
    logic             final_reg;
    logic             dropped_reg;

    pst_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .end_of_set   (end_of_set),
        .sort_mode_we (sort_mode_we),
        .sort_mode    (sort_mode),
        .busy         (busy),
        .ctl          (ctl),
        .seq          (seq)
    );

    always_comb
    begin
        in_rec.valid    = 1'b1;
        in_rec.seq      = seq;
        in_rec.first    = first_index;
        in_rec.second   = second_index;
        in_rec.island   = island_index;
        in_rec.distance = distance;
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY - 1; i++)
        begin : g_cmp
            assign gt[i] = cell_q[i].valid && cell_q[i+1].valid
                           && rec_greater(cell_q[i], cell_q[i+1], ctl.mode);
        end

        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic swap_up;
            logic swap_dn;
            rec_t lower_rec;
            rec_t upper_rec;

            if (i < CAPACITY - 1)
            begin : g_up
                assign swap_up   = (ctl.parity == 1'(i % 2)) && gt[i];
                assign upper_rec = cell_q[i+1];
            end else
            begin : g_top
                assign swap_up   = 1'b0;
                assign upper_rec = '0;
            end

            if (i > 0)
            begin : g_dn
                assign swap_dn   = (ctl.parity == 1'((i - 1) % 2)) && gt[i-1];
                assign lower_rec = cell_q[i-1];
            end else
            begin : g_bot
                assign swap_dn   = 1'b0;
                assign lower_rec = in_rec;
            end

            pst_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .swap_up   (swap_up),
                .swap_dn   (swap_dn),
                .lower_rec (lower_rec),
                .upper_rec (upper_rec),
                .rec       (cell_q[i])
            );
        end
    endgenerate

    assign result_valid_next = (ctl.op == OP_DRAIN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (result_valid_next)
        begin
            out_reg     <= cell_q[0];
            final_reg   <= ctl.last;
            dropped_reg <= ctl.dropped;
        end
    end

    assign result_valid = result_valid_reg;
    assign out_first    = out_reg.first;
    assign out_second   = out_reg.second;
    assign out_island   = out_reg.island;
    assign out_distance = out_reg.distance;
    assign final_record = final_reg;
    assign dropped      = dropped_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == OP_DRAIN) |-> cell_q[0].valid)
        else $error("drain from empty head cell");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && final_record) |=> !result_valid)
        else $error("result after final record");

    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == OP_SORT && CAPACITY > 1) |=> cell_q[0].valid)
        else $error("sort lost head record");

endmodule

FILE: src/pst_cell.sv
module pst_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  pst_pkg::ctrl_t ctl,
    input  logic          swap_up,
    input  logic          swap_dn,
    input  pst_pkg::rec_t lower_rec,
    input  pst_pkg::rec_t upper_rec,
    output pst_pkg::rec_t rec
);
    import pst_pkg::*;

    logic valid_reg;
    logic valid_next;
    rec_t data_reg;
    rec_t data_next;

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        case (ctl.op)
            OP_LOAD:
            begin
                data_next  = lower_rec;
                valid_next = lower_rec.valid;
            end
            OP_SORT:
            begin
                if (swap_up)
                begin
                    data_next  = upper_rec;
                    valid_next = upper_rec.valid;
                end else if (swap_dn)
                begin
                    data_next  = lower_rec;
                    valid_next = lower_rec.valid;
                end
            end
            OP_DRAIN:
            begin
                data_next  = upper_rec;
                valid_next = upper_rec.valid;
            end
            default:
            begin
                data_next  = data_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        rec       = data_reg;
        rec.valid = valid_reg;
    end

endmodule

FILE: src/pst_ctrl.sv
module pst_ctrl #(
    parameter int CAPACITY = pst_pkg::DEF_CAPACITY
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      end_of_set,
    input  logic                      sort_mode_we,
    input  logic                      sort_mode,
    output logic                      busy,
    output pst_pkg::ctrl_t            ctl,
    output logic [pst_pkg::SEQ_W-1:0] seq
);
    import pst_pkg::*;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] phase_reg;
    logic [CNT_W-1:0] phase_next;
    logic             overflow_reg;
    logic             overflow_next;
    sort_mode_t       mode_reg;
    sort_mode_t       mode_next;
    sort_mode_t       drain_mode_reg;
    sort_mode_t       drain_mode_next;
    logic             accept;
    logic             has_room;

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign has_room = (count_reg < CAP_CNT);
    assign seq      = count_reg[SEQ_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && end_of_set)
                    state_next = ST_SORT;
            end
            ST_SORT:
            begin
                if (phase_reg + 1'b1 == count_reg)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (count_reg == CNT_W'(1))
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        count_next      = count_reg;
        phase_next      = phase_reg;
        overflow_next   = overflow_reg;
        drain_mode_next = drain_mode_reg;
        mode_next       = sort_mode_we ? sort_mode_t'(sort_mode) : mode_reg;
        ctl.op          = OP_HOLD;
        ctl.parity      = phase_reg[0];
        ctl.mode        = drain_mode_reg;
        ctl.last        = (count_reg == CNT_W'(1));
        ctl.dropped     = overflow_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (has_room)
                    begin
                        ctl.op     = OP_LOAD;
                        count_next = count_reg + 1'b1;
                    end else
                        overflow_next = 1'b1;
                    if (end_of_set)
                    begin
                        phase_next      = '0;
                        drain_mode_next = mode_reg;
                    end
                end
            end
            ST_SORT:
            begin
                ctl.op     = OP_SORT;
                phase_next = phase_reg + 1'b1;
            end
            ST_DRAIN:
            begin
                ctl.op     = OP_DRAIN;
                count_next = count_reg - 1'b1;
                if (count_reg == CNT_W'(1))
                    overflow_next = 1'b0;
            end
            default:
                ctl.op = OP_HOLD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            phase_reg      <= '0;
            overflow_reg   <= 1'b0;
            mode_reg       <= MODE_ISLAND_DIST;
            drain_mode_reg <= MODE_ISLAND_DIST;
        end else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            phase_reg      <= phase_next;
            overflow_reg   <= overflow_next;
            mode_reg       <= mode_next;
            drain_mode_reg <= drain_mode_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CAP_CNT)
        else $error("held count above capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SORT || state_reg == ST_DRAIN) |-> count_reg != '0)
        else $error("sort or drain with empty store");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN && count_reg == CNT_W'(1))
            |=> (state_reg == ST_IDLE && count_reg == '0 && !overflow_reg))
        else $error("drain did not empty the store");

endmodule
